>>> design/bsa_pkg.sv
// Shared types and codes for the budgeted slot allocator.
package bsa_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int LIVE_W    = $clog2(NUM_SLOTS + 1);
  localparam int KEY_W     = 32;
  localparam int COST_W    = 42;
  localparam int BYTES_W   = 48;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EXISTS = 2'd1;
  localparam logic [1:0] ST_OOM    = 2'd2;

  localparam logic [1:0] CFG_BUDGET = 2'd0;
  localparam logic [1:0] CFG_LAYERS = 2'd1;
  localparam logic [1:0] CFG_HIDDEN = 2'd2;

  // One slot of the age-ordered chain
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [COST_W-1:0] cost;
  } entry_t;

endpackage

>>> design/bsa_if.sv
// Request and response channel interfaces.
interface bsa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] seq_id;
  logic [16:0] token_capacity;
  modport source (output valid, kind, seq_id, token_capacity, input ready);
  modport sink   (input valid, kind, seq_id, token_capacity, output ready);
endinterface

interface bsa_rsp_if;
  logic        valid;
  logic        ready;
  logic        is_eviction;
  logic [31:0] evicted_id;
  logic [1:0]  status;
  logic        present;
  logic [47:0] memory_used;
  logic [6:0]  active_count;
  logic        last;
  modport source (output valid, is_eviction, evicted_id, status, present,
                  memory_used, active_count, last, input ready);
  modport sink   (input valid, is_eviction, evicted_id, status, present,
                  memory_used, active_count, last, output ready);
endinterface

>>> design/bsa_cell.sv
// One slot cell of the age chain: compare, shift from right neighbor, append.
module bsa_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bsa_pkg::KEY_W-1:0] id_i,
  input  logic                     drop_en_i,
  input  logic                     shift_i,
  output logic                     shift_o,
  input  bsa_pkg::entry_t          nbr_i,
  input  logic                     wr_en_i,
  input  bsa_pkg::entry_t          wr_i,
  output bsa_pkg::entry_t          ent_o,
  output logic                     match_o
);
  import bsa_pkg::*;

  entry_t            ent_d;
  logic              valid_q;
  logic [KEY_W-1:0]  key_q;
  logic [COST_W-1:0] cost_q;

  assign match_o = valid_q && (key_q == id_i);
  // from the dropped slot on, every cell takes its right neighbor's entry
  assign shift_o = shift_i | (drop_en_i & match_o);
  assign ent_o   = '{valid: valid_q, key: key_q, cost: cost_q};

  always_comb begin
    ent_d = ent_o;
    if (shift_o) begin
      ent_d = nbr_i;
    end else if (wr_en_i) begin
      ent_d = wr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= ent_d.key;
    cost_q <= ent_d.cost;
  end

endmodule

>>> design/budgeted_slot_allocator_lru.sv
// Top level of the budgeted slot allocator with oldest-first eviction.
// Slots live in a chain of cells kept in allocation order, oldest at the
// head. Each request is taken in idle, then passes the multiplier states
// S_MUL1 and S_MUL2 (layers*hidden, then *tokens) and the decision state
// S_DEC, which gives one result per pass: free, lookup and rejected
// allocate give one result, an allocate with n evictions gives n+1.
// A response waiting in the output register stalls only the decision cycle.
module budgeted_slot_allocator_lru (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  bsa_req_if.sink     req,
  bsa_rsp_if.source   rsp
);
  import bsa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_DEC  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [47:0]        budget_q;
  logic [8:0]         layers_q;
  logic [14:0]        hidden_q;
  logic [1:0]         kind_q;
  logic [KEY_W-1:0]   id_q;
  logic [16:0]        tok_q;
  logic [23:0]        prod1_q;
  logic [43:0]        cost_q;
  logic [BYTES_W-1:0] used_q, used_d;
  logic [LIVE_W-1:0]  live_q, live_d;

  // output register
  logic        ov_q;
  logic        o_ev_q, o_pr_q, o_last_q;
  logic [31:0] o_id_q;
  logic [1:0]  o_st_q;
  logic        load;
  logic        o_ev, o_pr, o_last;
  logic [31:0] o_id;
  logic [1:0]  o_st;

  // chain wiring
  entry_t                ent   [NUM_SLOTS];
  entry_t                nbr   [NUM_SLOTS];
  logic [NUM_SLOTS:0]    shc;
  logic [NUM_SLOTS-1:0]  match, valid_v, wr_en;
  logic                  hit, drop_en, evict, append;
  entry_t                wr_ent;

  assign hit = |match;

  // fit test against cost range, table size and budget
  logic        cost_ok, fits;
  logic [48:0] sum;
  assign cost_ok = (cost_q[43:42] == 2'b00);
  assign sum     = {1'b0, used_q} + {5'b0, cost_q};
  assign fits    = cost_ok && (sum <= {1'b0, budget_q}) &&
                   (live_q < LIVE_W'(NUM_SLOTS));

  assign req.ready = (state_q == S_IDLE);
  logic out_free;
  assign out_free = !ov_q || rsp.ready;

  // state sequencing and decision logic
  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    live_d  = live_q;
    load    = 1'b0;
    drop_en = 1'b0;
    evict   = 1'b0;
    append  = 1'b0;
    o_ev    = 1'b0;
    o_id    = '0;
    o_st    = ST_OK;
    o_pr    = 1'b0;
    o_last  = 1'b1;
    unique case (state_q)
      S_IDLE: if (req.valid) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_DEC;
      default: begin
        if (out_free) begin
          load = 1'b1;
          state_d = S_IDLE;
          priority if (kind_q == KIND_ALLOC) begin
            priority if (hit) begin
              o_st = ST_EXISTS;
              o_pr = 1'b1;
            end else if (!fits && live_q != '0) begin
              evict   = 1'b1;
              o_ev    = 1'b1;
              o_id    = ent[0].key;
              o_last  = 1'b0;
              used_d  = used_q - {6'b0, ent[0].cost};
              live_d  = live_q - 1'b1;
              state_d = S_DEC;
            end else if (!fits) begin
              o_st = ST_OOM;
            end else begin
              append = 1'b1;
              used_d = sum[47:0];
              live_d = live_q + 1'b1;
            end
          end else if (kind_q == KIND_FREE) begin
            o_pr = hit;
            if (hit) begin
              drop_en = 1'b1;
              used_d  = used_q;
              for (int i = 0; i < NUM_SLOTS; i++) begin
                if (match[i]) used_d = used_q - {6'b0, ent[i].cost};
              end
              live_d = live_q - 1'b1;
            end
          end else begin
            o_pr = (kind_q == KIND_LOOKUP) && hit;
          end
        end
      end
    endcase
  end

  assign wr_ent = '{valid: 1'b1, key: id_q, cost: cost_q[COST_W-1:0]};
  assign shc[0] = evict;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    assign nbr[i]     = (i == NUM_SLOTS - 1) ? entry_t'('0) : ent[(i + 1) % NUM_SLOTS];
    assign wr_en[i]   = append && (live_q == LIVE_W'(i));
    assign valid_v[i] = ent[i].valid;
    bsa_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .id_i      (id_q),
      .drop_en_i (drop_en),
      .shift_i   (shc[i]),
      .shift_o   (shc[i+1]),
      .nbr_i     (nbr[i]),
      .wr_en_i   (wr_en[i]),
      .wr_i      (wr_ent),
      .ent_o     (ent[i]),
      .match_o   (match[i])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      live_q   <= '0;
      ov_q     <= 1'b0;
      budget_q <= 48'd4294967296;
      layers_q <= 9'd32;
      hidden_q <= 15'd4096;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      live_q  <= live_d;
      if (load) ov_q <= 1'b1;
      else if (rsp.ready) ov_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BUDGET: budget_q <= cfg_data_i;
          CFG_LAYERS: layers_q <= cfg_data_i[8:0];
          CFG_HIDDEN: hidden_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  // payload, multiplier and output registers
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      kind_q <= req.kind;
      id_q   <= req.seq_id;
      tok_q  <= req.token_capacity;
    end
    prod1_q <= layers_q * hidden_q;
    if (state_q == S_MUL2) cost_q <= {41'(prod1_q) * 41'(tok_q), 3'b000};
    if (load) begin
      o_ev_q   <= o_ev;
      o_id_q   <= o_id;
      o_st_q   <= o_st;
      o_pr_q   <= o_pr;
      o_last_q <= o_last;
    end
  end

  // used and live are sampled after the update, so they follow the result
  logic [BYTES_W-1:0] o_used_q;
  logic [LIVE_W-1:0]  o_live_q;
  always_ff @(posedge clk_i) begin
    if (load) begin
      o_used_q <= used_d;
      o_live_q <= live_d;
    end
  end

  assign rsp.valid        = ov_q;
  assign rsp.is_eviction  = o_ev_q;
  assign rsp.evicted_id   = o_id_q;
  assign rsp.status       = o_st_q;
  assign rsp.present      = o_pr_q;
  assign rsp.memory_used  = o_used_q;
  assign rsp.active_count = 7'(o_live_q);
  assign rsp.last         = o_last_q;

  // chain stays compact: occupied cells match the slot count
  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_v) == 32'(live_q))
    else $error("slot count disagrees with occupied cells");

  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.is_eviction |-> !rsp.last && rsp.status == ST_OK)
    else $error("eviction marked as final result");

  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("duplicate key in slot chain");

endmodule
